>>> src/windowed_duty_cycle_heater_gate_core_defines.svh
// Assertion macros for the heater gate core.
`ifndef WINDOWED_DUTY_CYCLE_HEATER_GATE_CORE_DEFINES_SVH
`define WINDOWED_DUTY_CYCLE_HEATER_GATE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define WDCHG_ASSERT_NOW(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("wdchg assertion failed");

`define WDCHG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wdchg assertion failed");

`else

`define WDCHG_ASSERT_NOW(label, prop)

`define WDCHG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/wdchg_pkg.sv
package wdchg_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_TEMP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_RISE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RISE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UPSWING      = 3'd4;

  localparam logic [16:0] DUTY_ONE  = 17'd65536;
  localparam int          DIV_STEPS = 17;

  typedef struct packed {
    logic load;
    logic add;
    logic sub;
    logic chk;
    logic div_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic div_short;
  } status_t;

endpackage

>>> src/windowed_duty_cycle_heater_gate_core.sv
// Windowed duty-cycle heater gate. Each check item (time, temperature, requested
// duty) updates the windowed on-time and recorded duty, checks for an
// unresponsive heater and returns one result item with the new heater drive.
// A check skips the division when the duty quotient is settled early (empty window,
// nonpositive on-time or a quotient at the cap) and otherwise runs the 17-step
// restoring divider that forms on-time / window length.
// A new check is taken once the previous one has reached the output register,
// and the result register holds its item until it is taken.
module windowed_duty_cycle_heater_gate_core
  import wdchg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 check_valid,
  output logic                 check_ready,
  input  logic [31:0]          now_ms,
  input  logic signed [15:0]   heater_temperature,
  input  logic [16:0]          requested_duty,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic                 heater_on,
  output logic [16:0]          recorded_duty_out,
  output logic                 fault_active,
  output logic                 fault_raised
);

  cmd_t    cmd;
  status_t status;

  wdchg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .check_valid  (check_valid),
    .check_ready  (check_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  wdchg_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .status             (status),
    .now_ms             (now_ms),
    .heater_temperature (heater_temperature),
    .requested_duty     (requested_duty),
    .heater_on          (heater_on),
    .recorded_duty_out  (recorded_duty_out),
    .fault_active       (fault_active),
    .fault_raised       (fault_raised)
  );

endmodule

>>> src/wdchg_ctrl.sv
`include "windowed_duty_cycle_heater_gate_core_defines.svh"

module wdchg_ctrl
  import wdchg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    check_valid,
  output logic    check_ready,
  output logic    result_valid,
  input  logic    result_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SUB,
    S_CHK,
    S_DIV,
    S_FIN
  } state_t;

  state_t     state;
  logic [4:0] cnt;

  assign check_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = check_valid && check_ready;
    cmd.add      = (state == S_ADD);
    cmd.sub      = (state == S_SUB);
    cmd.chk      = (state == S_CHK);
    cmd.div_step = (state == S_DIV);
    cmd.fin      = (state == S_FIN) && (!result_valid || result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.fin) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_ADD;
          end
        end
        S_ADD: state <= S_SUB;
        S_SUB: state <= S_CHK;
        S_CHK: begin
          cnt <= 5'(DIV_STEPS - 1);
          if (status.div_short) begin
            state <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_FIN: begin
          if (cmd.fin) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `WDCHG_ASSERT_NEXT(a_fin_shows_item, cmd.fin, result_valid && state == S_IDLE)
  `WDCHG_ASSERT_NEXT(a_div_ends, state == S_DIV && cnt == '0, state == S_FIN)
  `WDCHG_ASSERT_NOW(a_item_from_fin, $rose(result_valid) |-> $past(state == S_FIN))
  `WDCHG_ASSERT_NEXT(a_load_starts, cmd.load, state == S_ADD && !check_ready)

endmodule

>>> src/wdchg_dp.sv
module wdchg_dp
  import wdchg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [31:0]          now_ms,
  input  logic signed [15:0]   heater_temperature,
  input  logic [16:0]          requested_duty,
  output logic                 heater_on,
  output logic [16:0]          recorded_duty_out,
  output logic                 fault_active,
  output logic                 fault_raised
);

  localparam logic signed [50:0] WIDE_MAX = 51'sd140737488355327;
  localparam logic signed [50:0] WIDE_MIN = -51'sd140737488355328;

  function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
    if (v > WIDE_MAX) begin
      return WIDE_MAX[47:0];
    end else if (v < WIDE_MIN) begin
      return WIDE_MIN[47:0];
    end
    return v[47:0];
  endfunction

  logic [31:0]        window_length_limit;
  logic signed [15:0] split_temperature;
  logic signed [15:0] low_rise_limit;
  logic signed [15:0] high_rise_limit;
  logic signed [15:0] upswing_threshold;

  logic [31:0]        last_check_time;
  logic [31:0]        window_span;
  logic signed [47:0] prorata_on_time;
  logic [16:0]        recorded_duty;
  logic               heater_state;
  logic signed [15:0] last_temperature;
  logic               fault_latched;

  logic [31:0]        now_r;
  logic [31:0]        delta;
  logic signed [15:0] temp_r;
  logic [16:0]        req_r;
  logic [48:0]        prod;
  logic [47:0]        rem;
  logic [48:0]        dvs;
  logic [16:0]        quot;
  logic               zero_r;
  logic               cap_r;

  logic signed [50:0] sum_add;
  logic signed [50:0] sum_sub;
  logic [32:0]        span_sum;
  logic               div_zero;
  logic               div_cap;
  logic               div_ge;
  logic [16:0]        duty_next;
  logic signed [16:0] diff;
  logic signed [15:0] lim;
  logic               latched_next;
  logic               on_next;

  assign sum_add  = {{3{prorata_on_time[47]}}, prorata_on_time} + $signed({3'b000, delta, 16'h0});
  assign sum_sub  = {{3{prorata_on_time[47]}}, prorata_on_time} - $signed({2'b00, prod});
  assign span_sum = {1'b0, window_span} + {1'b0, delta};
  assign div_zero = (window_span == '0) || prorata_on_time[47] || (prorata_on_time == '0);
  assign div_cap  = {1'b0, prorata_on_time} >= {window_span, 17'h0};
  assign div_ge   = {1'b0, rem} >= dvs;
  assign status.div_short = div_zero || div_cap;

  always_comb begin
    if (zero_r) begin
      duty_next = '0;
    end else if (cap_r || (quot[16] && (quot[15:0] != '0))) begin
      duty_next = DUTY_ONE;
    end else begin
      duty_next = quot;
    end
    diff = 17'(temp_r) - 17'(last_temperature);
    lim  = (temp_r < split_temperature) ? low_rise_limit : high_rise_limit;
    latched_next = fault_latched;
    if (heater_state && !fault_latched && (diff <= 17'(lim))) begin
      latched_next = !(diff >= 17'(upswing_threshold));
    end
    on_next = (req_r != '0) && (duty_next <= req_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length_limit <= 32'd30000;
      split_temperature   <= 16'sd960;
      low_rise_limit      <= '0;
      high_rise_limit     <= '0;
      upswing_threshold   <= 16'sd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_LIMIT: window_length_limit <= cfg_data;
        CFG_SPLIT_TEMP:   split_temperature   <= cfg_data[15:0];
        CFG_LOW_RISE:     low_rise_limit      <= cfg_data[15:0];
        CFG_HIGH_RISE:    high_rise_limit     <= cfg_data[15:0];
        CFG_UPSWING:      upswing_threshold   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_check_time  <= '0;
      window_span      <= '0;
      prorata_on_time  <= '0;
      recorded_duty    <= '0;
      heater_state     <= 1'b0;
      last_temperature <= '0;
      fault_latched    <= 1'b0;
    end else begin
      if (cmd.add) begin
        if (heater_state) begin
          prorata_on_time <= sat48(sum_add);
        end
        if (window_span < window_length_limit) begin
          window_span <= span_sum[32] ? '1 : span_sum[31:0];
        end
      end
      if (cmd.sub) begin
        prorata_on_time <= sat48(sum_sub);
      end
      if (cmd.fin) begin
        last_check_time  <= now_r;
        last_temperature <= temp_r;
        recorded_duty    <= duty_next;
        heater_state     <= on_next;
        fault_latched    <= latched_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r  <= now_ms;
      temp_r <= heater_temperature;
      req_r  <= requested_duty;
      delta  <= now_ms - last_check_time;
    end
    if (cmd.add) begin
      prod <= 49'(recorded_duty) * 49'(delta);
    end
    if (cmd.chk) begin
      zero_r <= div_zero;
      cap_r  <= div_cap;
      rem    <= prorata_on_time[47:0];
      dvs    <= {1'b0, window_span, 16'h0};
      quot   <= '0;
    end
    if (cmd.div_step) begin
      if (div_ge) begin
        rem <= rem - dvs[47:0];
      end
      quot <= {quot[15:0], div_ge};
      dvs  <= dvs >> 1;
    end
    if (cmd.fin) begin
      heater_on         <= on_next;
      recorded_duty_out <= duty_next;
      fault_active      <= latched_next;
      fault_raised      <= latched_next && !fault_latched;
    end
  end

endmodule
